/* design/dnsqp_pkg.sv */
// Shared types, constants and helpers for the DNS question parser.
// Depends on nothing; every other file in this block imports it.
package dnsqp_pkg;

  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned MaxLabel    = 63;
  localparam int unsigned TailBytes   = 4;

  localparam logic [7:0] DotChar      = 8'd46;
  localparam logic [7:0] NameLimitRst = 8'd255;

  // Width of the packed result word on the output stream.
  localparam int unsigned OutDataW    = 56;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG_LBL  = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NAME_LONG = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    TC_A     = 3'd0,
    TC_AAAA  = 3'd1,
    TC_NS    = 3'd2,
    TC_CNAME = 3'd3,
    TC_MX    = 3'd4,
    TC_TXT   = 3'd5,
    TC_SRV   = 3'd6,
    TC_OTHER = 3'd7
  } type_class_e;

  typedef struct packed {
    logic        final_res;
    logic [8:0]  query_length;
    logic [15:0] query_class;
    logic [2:0]  type_class;
    logic [15:0] query_type;
    logic [2:0]  status;
    logic [7:0]  name_char;
  } result_t;

  function automatic logic [2:0] classify(input logic [15:0] qtype);
    logic [2:0] tc;
    case (qtype)
      16'd1:   tc = TC_A;
      16'd28:  tc = TC_AAAA;
      16'd2:   tc = TC_NS;
      16'd5:   tc = TC_CNAME;
      16'd15:  tc = TC_MX;
      16'd16:  tc = TC_TXT;
      16'd33:  tc = TC_SRV;
      default: tc = TC_OTHER;
    endcase
    return tc;
  endfunction

endpackage

/* design/dns_question_parser_top.sv */
// Top level of the DNS question section parser.
// Instantiates dnsqp_parse and dnsqp_outbuf; uses dnsqp_pkg.
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata[7:0] packet byte, tlast marks the final message byte
//  m_axis    out        tuser final result flag, tdata name char / status / query fields
//  cfg       in         cfg_wdata_i is the name limit, written when cfg_we_i is high
//
// Each input word is registered, decoded combinationally by the parse logic,
// and any result is written to a two-entry output buffer, so a word can be
// accepted every cycle while the output is drained. A stalled output fills
// the buffer and then holds the input register, which in turn drops
// s_axis_tready. Reset restores the header phase and a name limit of 255.
module dns_question_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: [7:0] packet_byte
  input  logic [7:0]                      s_axis_tdata,
  // tlast: last_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: [7:0] name_char, [10:8] status, [26:11] query_type,
  //        [29:27] type_class, [45:30] query_class, [54:46] query_length, [55] zero
  output logic [dnsqp_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: final_res
  output logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [7:0]                      cfg_wdata_i
);
  import dnsqp_pkg::*;

  logic    res_valid;
  result_t res;
  logic    buf_space;
  result_t out_res;

  dnsqp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .buf_ready_i (buf_space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dnsqp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (buf_space),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready)
  );

  // The result struct without its flag is exactly the low 55 bits of tdata.
  assign m_axis_tdata = {1'b0, out_res.query_length, out_res.query_class,
                         out_res.type_class, out_res.query_type, out_res.status,
                         out_res.name_char};
  assign m_axis_tuser = out_res.final_res;

endmodule

/* design/dnsqp_parse.sv */
// Input word register and per-byte parse logic of the DNS question parser.
// Holds the parse state and the name limit register; uses dnsqp_pkg.
module dnsqp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                buf_ready_i,
  output logic                res_valid_o,
  output dnsqp_pkg::result_t  res_o
);
  import dnsqp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic [7:0]  name_limit_q;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [5:0]  lab_q, lab_d;
  logic [7:0]  name_len_q, name_len_d;
  logic [8:0]  wire_len_q, wire_len_d;
  logic [23:0] hold_q, hold_d;

  logic        fire;
  logic        have_res;
  result_t     res;
  logic        over_limit;
  logic [15:0] qtype;

  assign fire       = in_valid_q && buf_ready_i;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q <= NameLimitRst;
    end else if (cfg_we_i) begin
      name_limit_q <= cfg_wdata_i;
    end
  end

  // One more dotted character would exceed the configured limit.
  assign over_limit = ({1'b0, name_len_q} + 9'd1) > {1'b0, name_limit_q};
  assign qtype      = hold_q[23:8];

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    lab_d      = lab_q;
    name_len_d = name_len_q;
    wire_len_d = wire_len_q;
    hold_d     = hold_q;
    have_res   = 1'b0;
    res        = '0;

    case (phase_q)
      PH_HEADER: begin
        if (in_last_q) begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_SHORT;
          phase_d = PH_DONE;
        end else if (cnt_q == 4'(HeaderBytes - 1)) begin
          cnt_d = '0;
          phase_d = PH_LENGTH;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_LENGTH: begin
        if (in_byte_q == 8'd0) begin
          if (name_len_q == 8'd0) begin
            have_res = 1'b1;
            res.final_res = 1'b1;
            res.status = ST_EMPTY;
            phase_d = PH_DONE;
          end else if (in_last_q) begin
            have_res = 1'b1;
            res.final_res = 1'b1;
            res.status = ST_TRUNC;
            phase_d = PH_DONE;
          end else begin
            wire_len_d = wire_len_q + 9'd1;
            cnt_d = '0;
            hold_d = '0;
            phase_d = PH_TAIL;
          end
        end else if (in_byte_q > 8'(MaxLabel)) begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_LONG_LBL;
          phase_d = PH_DONE;
        end else if (in_last_q) begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_TRUNC;
          phase_d = PH_DONE;
        end else if (name_len_q != 8'd0 && over_limit) begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_NAME_LONG;
          phase_d = PH_DONE;
        end else begin
          wire_len_d = wire_len_q + 9'd1;
          lab_d = in_byte_q[5:0];
          phase_d = PH_LABEL;
          // Labels after the first are preceded by a dot.
          if (name_len_q != 8'd0) begin
            name_len_d = name_len_q + 8'd1;
            have_res = 1'b1;
            res.name_char = DotChar;
          end
        end
      end
      PH_LABEL: begin
        if (in_last_q) begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_TRUNC;
          phase_d = PH_DONE;
        end else if (over_limit) begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_NAME_LONG;
          phase_d = PH_DONE;
        end else begin
          name_len_d = name_len_q + 8'd1;
          wire_len_d = wire_len_q + 9'd1;
          lab_d = lab_q - 6'd1;
          if (lab_q == 6'd1) begin
            phase_d = PH_LENGTH;
          end
          have_res = 1'b1;
          res.name_char = in_byte_q;
        end
      end
      PH_TAIL: begin
        if (cnt_q < 4'(TailBytes - 1)) begin
          if (in_last_q) begin
            have_res = 1'b1;
            res.final_res = 1'b1;
            res.status = ST_TRUNC;
            phase_d = PH_DONE;
          end else begin
            hold_d = {hold_q[15:0], in_byte_q};
            cnt_d = cnt_q + 4'd1;
          end
        end else begin
          have_res = 1'b1;
          res.final_res = 1'b1;
          res.status = ST_OK;
          res.query_type = qtype;
          res.type_class = classify(qtype);
          res.query_class = {hold_q[7:0], in_byte_q};
          res.query_length = wire_len_q + 9'(TailBytes);
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        // Remaining bytes of the message are dropped.
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // The final byte of a message always returns the parser to its start.
    if (in_last_q) begin
      phase_d    = PH_HEADER;
      cnt_d      = '0;
      lab_d      = '0;
      name_len_d = '0;
      wire_len_d = '0;
      hold_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      cnt_q      <= '0;
      lab_q      <= '0;
      name_len_q <= '0;
      wire_len_q <= '0;
      hold_q     <= '0;
    end else if (fire) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      lab_q      <= lab_d;
      name_len_q <= name_len_d;
      wire_len_q <= wire_len_d;
      hold_q     <= hold_d;
    end
  end

  assign res_valid_o = fire && have_res;
  assign res_o       = res;

endmodule

/* design/dnsqp_outbuf.sv */
// Two-entry result buffer that decouples the parser from the output stream.
// Stores dnsqp_pkg::result_t words; uses dnsqp_pkg.
module dnsqp_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dnsqp_pkg::result_t  push_data_i,
  output logic                space_o,
  output logic                valid_o,
  output dnsqp_pkg::result_t  data_o,
  input  logic                pop_ready_i
);
  import dnsqp_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sim/dns_question_parser_top_tb.sv */
// Self-checking testbench for dns_question_parser_top: a DNS message stream goes in,
// dotted name characters and one closing word per message come out.
// Depends on dnsqp_pkg for the phase, status and type class codes and on the block itself.
module dns_question_parser_top_tb;
  import dnsqp_pkg::*;

  // QTYPE codes used by the stimulus. The first seven map onto their own type class.
  localparam logic [15:0] QT_A     = 16'd1;
  localparam logic [15:0] QT_AAAA  = 16'd28;
  localparam logic [15:0] QT_NS    = 16'd2;
  localparam logic [15:0] QT_CNAME = 16'd5;
  localparam logic [15:0] QT_MX    = 16'd15;
  localparam logic [15:0] QT_TXT   = 16'd16;
  localparam logic [15:0] QT_SRV   = 16'd33;
  localparam logic [15:0] QT_ANY   = 16'd255;
  localparam logic [15:0] QT_ZERO  = 16'd0;
  localparam logic [15:0] QT_MAX   = 16'hFFFF;
  localparam int          QT_COUNT = 10;

  // The slowest correct run stays well below this: about 2000 words, each one at worst
  // waiting out the longest sender gap and receiver stall, plus the long hold.
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic [7:0] val;
    bit         is_last;
  } msg_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'd0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [7:0]           cfg_wdata_i = 8'd0;

  dns_question_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Message bytes waiting to be offered, and the words the parser is expected to produce.
  msg_word_t   msg_bytes[$];
  result_t     due_results[$];
  logic [7:0]  pkt[$];
  int unsigned queued_items = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // Our own copy of the parser state and of the name limit register.
  phase_e      phase_m = PH_HEADER;
  logic [3:0]  count_m = '0;
  logic [5:0]  label_left_m = '0;
  logic [7:0]  name_len_m = '0;
  logic [8:0]  wire_len_m = '0;
  logic [23:0] tail_hold_m = '0;
  logic [7:0]  limit_m = NameLimitRst;

  // Driver, receiver and long hold-off bookkeeping.
  bit          tx_busy = 1'b0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          calm;
  msg_word_t   tx_word;
  result_t     tx_res;
  result_t     rx_want;

  // During one window out of every four both sides run without any gaps.
  assign calm = ((cycle_count / 1500) % 4) == 2;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [15:0] qtype_by_index(input int i);
    case (i)
      0:       return QT_A;
      1:       return QT_AAAA;
      2:       return QT_NS;
      3:       return QT_CNAME;
      4:       return QT_MX;
      5:       return QT_TXT;
      6:       return QT_SRV;
      7:       return QT_ANY;
      8:       return QT_ZERO;
      default: return QT_MAX;
    endcase
  endfunction

  function automatic logic [15:0] pick_qtype();
    int r;
    r = $urandom_range(0, 13);
    if (r < QT_COUNT) return qtype_by_index(r);
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void clear_parse_state();
    phase_m      = PH_HEADER;
    count_m      = '0;
    label_left_m = '0;
    name_len_m   = '0;
    wire_len_m   = '0;
    tail_hold_m  = '0;
  endfunction

  // Advances our copy of the parser by one message byte. Returns 1 when the byte
  // produces an output word, which is then left in r.
  function automatic bit parse_question_byte(input logic [7:0] b, input bit last,
                                             output result_t r);
    bit      emitted;
    bit      closing;
    status_e fin;
    emitted = 1'b0;
    closing = 1'b0;
    fin     = ST_OK;
    r       = '0;
    case (phase_m)
      PH_HEADER: begin
        if (last) begin
          closing = 1'b1;
          fin     = ST_SHORT;
        end else begin
          count_m = count_m + 4'd1;
          if (count_m >= HeaderBytes) begin
            count_m = '0;
            phase_m = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        if (b == 8'd0) begin
          // The terminator: an empty name wins over truncation.
          if (name_len_m == 8'd0) begin
            closing = 1'b1;
            fin     = ST_EMPTY;
          end else if (last) begin
            closing = 1'b1;
            fin     = ST_TRUNC;
          end else begin
            wire_len_m  = wire_len_m + 9'd1;
            count_m     = '0;
            tail_hold_m = '0;
            phase_m     = PH_TAIL;
          end
        end else if (b > MaxLabel) begin
          closing = 1'b1;
          fin     = ST_LONG_LBL;
        end else if (last) begin
          closing = 1'b1;
          fin     = ST_TRUNC;
        end else if (name_len_m != 8'd0 && int'(name_len_m) + 1 > int'(limit_m)) begin
          closing = 1'b1;
          fin     = ST_NAME_LONG;
        end else begin
          wire_len_m   = wire_len_m + 9'd1;
          label_left_m = b[5:0];
          phase_m      = PH_LABEL;
          // Every label after the first is preceded by a dot in the text.
          if (name_len_m != 8'd0) begin
            name_len_m  = name_len_m + 8'd1;
            r.name_char = DotChar;
            emitted     = 1'b1;
          end
        end
      end
      PH_LABEL: begin
        if (last) begin
          closing = 1'b1;
          fin     = ST_TRUNC;
        end else if (int'(name_len_m) + 1 > int'(limit_m)) begin
          closing = 1'b1;
          fin     = ST_NAME_LONG;
        end else begin
          name_len_m   = name_len_m + 8'd1;
          wire_len_m   = wire_len_m + 9'd1;
          label_left_m = label_left_m - 6'd1;
          if (label_left_m == 6'd0) phase_m = PH_LENGTH;
          r.name_char = b;
          emitted     = 1'b1;
        end
      end
      PH_TAIL: begin
        if (int'(count_m) + 1 < TailBytes) begin
          if (last) begin
            closing = 1'b1;
            fin     = ST_TRUNC;
          end else begin
            tail_hold_m = {tail_hold_m[15:0], b};
            count_m     = count_m + 4'd1;
          end
        end else begin
          // Fourth byte after the terminator: QTYPE and QCLASS are complete.
          r.query_type   = tail_hold_m[23:8];
          r.query_class  = {tail_hold_m[7:0], b};
          r.query_length = wire_len_m + 9'(TailBytes);
          case (r.query_type)
            QT_A:     r.type_class = TC_A;
            QT_AAAA:  r.type_class = TC_AAAA;
            QT_NS:    r.type_class = TC_NS;
            QT_CNAME: r.type_class = TC_CNAME;
            QT_MX:    r.type_class = TC_MX;
            QT_TXT:   r.type_class = TC_TXT;
            QT_SRV:   r.type_class = TC_SRV;
            default:  r.type_class = TC_OTHER;
          endcase
          closing = 1'b1;
          fin     = ST_OK;
        end
      end
      default: begin
        // Done: everything up to the final byte is ignored.
      end
    endcase
    if (closing) begin
      r.final_res = 1'b1;
      r.status    = fin;
      phase_m     = PH_DONE;
      emitted     = 1'b1;
    end
    if (last) clear_parse_state();
    return emitted;
  endfunction

  // Sender: offers the queued message bytes with random gaps. The prediction is made
  // at the edge where the byte is taken, so it sees exactly the accepted sequence.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'd0;
      s_axis_tlast  <= 1'b0;
      tx_busy = 1'b0;
      tx_gap  = 0;
    end else begin
      if (tx_busy && s_axis_tready) begin
        if (parse_question_byte(s_axis_tdata, s_axis_tlast, tx_res)) begin
          due_results.push_back(tx_res);
        end
        tx_busy = 1'b0;
        tx_gap  = pick_gap();
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
        end else if (msg_bytes.size() > 0) begin
          tx_word = msg_bytes.pop_front();
          s_axis_tdata <= tx_word.val;
          s_axis_tlast <= tx_word.is_last;
          tx_busy = 1'b1;
        end
      end
      // A single assignment per edge, so back-to-back words keep tvalid high.
      s_axis_tvalid <= tx_busy;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps going meanwhile.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endtask

  // Receiver: takes output words with random stalls and checks each against the
  // oldest expectation, field by field.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected output word: tuser %b tdata %h", m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          rx_want = due_results.pop_front();
          check_field("final_res",    rx_want.final_res,    m_axis_tuser);
          check_field("name_char",    rx_want.name_char,    m_axis_tdata[7:0]);
          check_field("status",       rx_want.status,       m_axis_tdata[10:8]);
          check_field("query_type",   rx_want.query_type,   m_axis_tdata[26:11]);
          check_field("type_class",   rx_want.type_class,   m_axis_tdata[29:27]);
          check_field("query_class",  rx_want.query_class,  m_axis_tdata[45:30]);
          check_field("query_length", rx_want.query_length, m_axis_tdata[54:46]);
        end
        rx_stall = pick_gap();
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall = rx_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Message building: a scratch message is assembled in pkt, then queued with the
  // last flag on its final byte.
  task automatic open_msg();
    pkt.delete();
    repeat (HeaderBytes) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_label(input logic [7:0] len_byte, input int n_chars);
    pkt.push_back(len_byte);
    repeat (n_chars) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_tail(input logic [15:0] qtype, input logic [15:0] qclass);
    pkt.push_back(8'd0);
    pkt.push_back(qtype[15:8]);
    pkt.push_back(qtype[7:0]);
    pkt.push_back(qclass[15:8]);
    pkt.push_back(qclass[7:0]);
  endtask

  task automatic queue_msg();
    int        i;
    msg_word_t w;
    for (i = 0; i < pkt.size(); i++) begin
      w.val     = pkt[i];
      w.is_last = (i == pkt.size() - 1);
      msg_bytes.push_back(w);
    end
    queued_items += pkt.size();
    pkt.delete();
  endtask

  task automatic cut_msg(input int keep);
    while (pkt.size() > keep) void'(pkt.pop_back());
  endtask

  // One random message: mostly well-formed questions with random names and codes,
  // the rest cut short, carrying an oversized label or an empty name, or plain noise.
  task automatic queue_random_msg();
    int mode;
    int nl;
    int bad;
    int len;
    int i;
    mode = $urandom_range(0, 99);
    if (mode >= 95) begin
      pkt.delete();
      repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      open_msg();
      nl  = (mode >= 85 && mode < 90) ? 0 : $urandom_range(1, 4);
      bad = (mode >= 75 && mode < 85) ? $urandom_range(0, nl - 1) : -1;
      for (i = 0; i < nl; i++) begin
        if (i == bad) begin
          add_label(8'($urandom_range(MaxLabel + 1, 255)), $urandom_range(0, 4));
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxLabel) :
                                              $urandom_range(1, 6);
          add_label(8'(len), len);
        end
      end
      add_tail(pick_qtype(), 16'($urandom_range(0, 65535)));
      // Bytes after the question are ignored up to the final byte.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom_range(0, 255)));
      end
      if (mode >= 60 && mode < 75) cut_msg($urandom_range(1, pkt.size()));
    end
    queue_msg();
  endtask

  // Waits until every byte is taken and every expected word has arrived, then waits
  // on so that a byte with no output has also left the parser.
  task automatic settle();
    @(posedge clk_i);
    while (msg_bytes.size() != 0 || tx_busy || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_name_limit(input logic [7:0] lim);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_m = lim;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    start = queued_items;
    while (queued_items - start < n_items) queue_random_msg();
  endtask

  initial begin : stimulus
    int i;
    int keep;
    clear_parse_state();
    limit_m = NameLimitRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Header cut short on its first byte and on its twelfth.
    pkt.delete();
    pkt.push_back(8'($urandom_range(0, 255)));
    queue_msg();
    open_msg();
    queue_msg();

    // A two label name with every QTYPE of interest, QCLASS alternating between 1 and 0xFFFF.
    for (i = 0; i < QT_COUNT; i++) begin
      open_msg();
      add_label(8'd1, 1);
      add_label(8'd2, 2);
      add_tail(qtype_by_index(i), (i % 2 == 0) ? 16'h0001 : 16'hFFFF);
      queue_msg();
    end

    // Empty name: the terminator comes first, the rest is ignored.
    open_msg();
    add_tail(QT_A, 16'd1);
    queue_msg();

    // Label lengths just over the maximum, a compression pointer, and 255.
    open_msg();
    add_label(8'(MaxLabel + 1), 3);
    add_tail(QT_A, 16'd1);
    queue_msg();
    open_msg();
    pkt.push_back(8'hC0);
    pkt.push_back(8'h0C);
    queue_msg();
    open_msg();
    add_label(8'hFF, 0);
    queue_msg();

    // A full 63 byte label, followed by trailing bytes that must be ignored.
    open_msg();
    add_label(8'(MaxLabel), MaxLabel);
    add_tail(QT_MX, 16'd1);
    repeat (3) pkt.push_back(8'($urandom_range(0, 255)));
    queue_msg();

    // Truncation on a length byte, a label byte, the terminator and the tail bytes.
    for (i = 0; i < 7; i++) begin
      case (i)
        0: keep = 13;
        1: keep = 14;
        2: keep = 16;
        3: keep = 18;
        4: keep = 19;
        5: keep = 20;
        default: keep = 21;
      endcase
      open_msg();
      add_label(8'd2, 2);
      add_label(8'd1, 1);
      add_tail(QT_A, 16'd1);
      cut_msg(keep);
      queue_msg();
    end

    // Name exactly at the reset limit of 255, then one over on a dot and one mid-label.
    open_msg();
    repeat (4) add_label(8'(MaxLabel), MaxLabel);
    add_tail(QT_TXT, 16'd1);
    queue_msg();
    open_msg();
    repeat (5) add_label(8'(MaxLabel), MaxLabel);
    add_tail(QT_TXT, 16'd1);
    queue_msg();
    open_msg();
    repeat (3) add_label(8'(MaxLabel), MaxLabel);
    add_label(8'd62, 62);
    add_label(8'd5, 5);
    add_tail(QT_SRV, 16'd1);
    queue_msg();

    // Smallest limit: one character passes, a second character or a dot does not.
    set_name_limit(8'd1);
    open_msg();
    add_label(8'd1, 1);
    add_tail(QT_A, 16'd1);
    queue_msg();
    open_msg();
    add_label(8'd2, 2);
    add_tail(QT_A, 16'd1);
    queue_msg();
    open_msg();
    add_label(8'd1, 1);
    add_label(8'd1, 1);
    add_tail(QT_A, 16'd1);
    queue_msg();

    // Random phases over several limits. During the first the receiver holds off
    // long enough for the output buffer to fill and the input to stall.
    set_name_limit(8'($urandom_range(2, 30)));
    run_random(50);
    hold_req <= 1'b1;
    set_name_limit(8'd1);
    run_random(30);
    set_name_limit(8'($urandom_range(31, 254)));
    run_random(50);
    set_name_limit(8'd255);
    run_random(70);

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
